/* hdl/cosine_palette_color_map_macros.svh */
// Assertion macros shared by the colour mapper RTL.
`ifndef COSINE_PALETTE_COLOR_MAP_MACROS_SVH
`define COSINE_PALETTE_COLOR_MAP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CPCM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CPCM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/cpcm_pkg.sv */
// Types, constants, palette tables and cosine ROM for the colour mapper.
package cpcm_pkg;

   localparam int PHASE_BITS = 10;
   localparam int COLOR_BITS = 8;

   // field widths
   localparam int IDX_W = 24;
   localparam int OUT_W = 8;
   localparam int SEL_W = 3;
   localparam int FRAC_W = 8;             // fraction bits of the iteration count
   localparam int Q_W = IDX_W - FRAC_W;   // integer part of the iteration count
   localparam int R_W = 5;                // remainder modulo the period
   localparam int T_W = 16;               // phase fraction t, Q0.16
   localparam int X_W = R_W + FRAC_W + 8; // r * 256
   localparam int COEF_W = 17;
   localparam int PH_W = 30;
   localparam int D_SHIFT = 16;
   localparam int COS_W = 16;
   localparam int ROM_W = 15;
   localparam int S_W = 32;
   localparam int SC_W = S_W - 1 + COLOR_BITS;
   localparam int V_W = SC_W - 28;
   localparam int FIT_W = (COLOR_BITS > OUT_W) ? COLOR_BITS : OUT_W;
   localparam int QUARTER = 2 ** (PHASE_BITS - 2);
   localparam int ADDR_W = PHASE_BITS - 1;

   // periods and reciprocals, floor(x / P) = (x * ceil(2^s / P)) >> s
   localparam int PERIOD_SHORT = 20;
   localparam int PERIOD_MID = 25;
   localparam int PERIOD_LONG = 30;
   localparam int Q_SHIFT = Q_W + R_W;
   localparam int T_SHIFT = X_W + R_W;
   localparam int RQ_W = 17;
   localparam int RT_W = 22;
   localparam int PQ_W = Q_W + RQ_W;
   localparam int PT_W = X_W + RT_W;
   localparam logic [RQ_W-1:0] RQ_SHORT = RQ_W'(((2 ** Q_SHIFT) + PERIOD_SHORT - 1) / PERIOD_SHORT);
   localparam logic [RQ_W-1:0] RQ_MID = RQ_W'(((2 ** Q_SHIFT) + PERIOD_MID - 1) / PERIOD_MID);
   localparam logic [RQ_W-1:0] RQ_LONG = RQ_W'(((2 ** Q_SHIFT) + PERIOD_LONG - 1) / PERIOD_LONG);
   localparam logic [RT_W-1:0] RT_SHORT = RT_W'(((2 ** T_SHIFT) + PERIOD_SHORT - 1) / PERIOD_SHORT);
   localparam logic [RT_W-1:0] RT_MID = RT_W'(((2 ** T_SHIFT) + PERIOD_MID - 1) / PERIOD_MID);
   localparam logic [RT_W-1:0] RT_LONG = RT_W'(((2 ** T_SHIFT) + PERIOD_LONG - 1) / PERIOD_LONG);

   localparam int LATENCY = 8;

   typedef enum logic [SEL_W-1:0] {
      PAL_0 = 3'd0,
      PAL_1 = 3'd1,
      PAL_2 = 3'd2,
      PAL_3 = 3'd3,
      PAL_4 = 3'd4
   } pal_type;

   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } chan_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
      logic signed [COEF_W-1:0] d;
   } coef_type;

   typedef struct packed {
      logic [T_W-1:0] t;
      pal_type        pal;
   } lane_in_type;

   function automatic coef_type cf(input int a, input int b, input int c, input int d);
      coef_type r;
      r.a = COEF_W'(a);
      r.b = COEF_W'(b);
      r.c = COEF_W'(c);
      r.d = COEF_W'(d);
      return r;
   endfunction

   // Q2.14 coefficients, per palette then per channel
   localparam coef_type COEF_TABLE [5][3] = '{
      '{cf(12698, 3686, 16384, 0), cf(14746, 1638, 16384, 0), cf(16384, 0, 16384, 0)},
      '{cf(2785, 983, 11469, 983), cf(8192, 7373, 6554, 4915), cf(6554, 3277, 16220, 1638)},
      '{cf(13107, 3277, 32768, 0), cf(8192, 6554, 16384, 4915),
        cf(6554, 3277, 16384, 4096)},
      '{cf(9830, -3277, 32768, 4096), cf(9830, -3277, 32768, 8192),
        cf(9830, -3277, 32768, 12288)},
      '{cf(8192, 8192, 16384, 0), cf(8192, 8192, 16384, 1638), cf(8192, 8192, 16384, 1638)}
   };

   function automatic coef_type coef_of(input pal_type pal, input chan_type ch);
      return COEF_TABLE[pal][ch];
   endfunction

   function automatic logic [R_W-1:0] period_of(input pal_type pal);
      logic [R_W-1:0] p;
      unique case (pal)
         PAL_0:        p = R_W'(PERIOD_SHORT);
         PAL_1, PAL_2: p = R_W'(PERIOD_LONG);
         PAL_3, PAL_4: p = R_W'(PERIOD_MID);
         default:      p = R_W'(PERIOD_MID);
      endcase
      return p;
   endfunction

   function automatic logic [RQ_W-1:0] recip_q(input pal_type pal);
      logic [RQ_W-1:0] r;
      unique case (pal)
         PAL_0:        r = RQ_SHORT;
         PAL_1, PAL_2: r = RQ_LONG;
         PAL_3, PAL_4: r = RQ_MID;
         default:      r = RQ_MID;
      endcase
      return r;
   endfunction

   function automatic logic [RT_W-1:0] recip_t(input pal_type pal);
      logic [RT_W-1:0] r;
      unique case (pal)
         PAL_0:        r = RT_SHORT;
         PAL_1, PAL_2: r = RT_LONG;
         PAL_3, PAL_4: r = RT_MID;
         default:      r = RT_MID;
      endcase
      return r;
   endfunction

   // quarter-wave cosine, Q30 Taylor series rounded to Q1.14 (elaboration only)
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   function automatic logic [ROM_W-1:0] rom_entry(input int unsigned j);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x = (TWO_PI_Q30 * 64'(j)) >> PHASE_BITS;
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      sum = 64'sd1 <<< 30;
      for (int n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
         if ((n % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 64'sd32768) >>> 16;
      if (sum > 64'sd16384) begin
         sum = 64'sd16384;
      end
      return ROM_W'(sum);
   endfunction

   typedef logic [ROM_W-1:0] rom_type [QUARTER];

   function automatic rom_type build_rom();
      rom_type r;
      for (int j = 0; j < QUARTER; j++) begin
         r[j] = rom_entry(j);
      end
      return r;
   endfunction

   localparam rom_type COS_ROM = build_rom();
   localparam logic [ROM_W-1:0] COS_ROM_TOP = rom_entry(QUARTER);

endpackage

/* hdl/cpcm_lane.sv */
// One colour channel: phase, cosine lookup, affine term and scaling.
module cpcm_lane import cpcm_pkg::*; (
   input  logic              clock,
   input  chan_type          chan,
   input  lane_in_type       lane_in,
   output logic [OUT_W-1:0]  color
);

   // L1: c * t
   logic [PH_W-1:0]          l1_prod_ff;
   logic [PH_W-1:0]          l1_prod_in;
   pal_type                  l1_pal_ff;
   // L2: phase wrap, quadrant fold
   logic [ADDR_W-1:0]        l2_addr_ff;
   logic [ADDR_W-1:0]        l2_addr_in;
   logic                     l2_neg_ff;
   logic                     l2_neg_in;
   pal_type                  l2_pal_ff;
   // L3: ROM
   logic signed [COS_W-1:0]  l3_cos_ff;
   logic signed [COS_W-1:0]  l3_cos_in;
   pal_type                  l3_pal_ff;
   // L4: a + b*cos
   logic signed [S_W-1:0]    l4_sum_ff;
   logic signed [S_W-1:0]    l4_sum_in;
   // L5: scale and saturate
   logic [OUT_W-1:0]         color_ff;
   logic [OUT_W-1:0]         color_in;

   coef_type                 c1;
   coef_type                 c2;
   coef_type                 c4;
   logic signed [T_W+COEF_W:0] prod1;
   logic [PH_W-1:0]          phase;
   logic [PHASE_BITS-1:0]    k;
   logic [1:0]               quad;
   logic [ADDR_W-1:0]        j_ext;
   logic [ROM_W-1:0]         rom_q;
   logic signed [COS_W-1:0]  cos_mag;
   logic [S_W-2:0]           pos;
   logic [SC_W-1:0]          scaled;
   logic [V_W-1:0]           v;
   logic [COLOR_BITS-1:0]    sat;
   logic [FIT_W-1:0]         fit;

   assign c1 = coef_of(lane_in.pal, chan);
   assign c2 = coef_of(l1_pal_ff, chan);
   assign c4 = coef_of(l3_pal_ff, chan);

   // product wraps modulo 2^30 anyway
   assign prod1 = (T_W + COEF_W + 1)'(c1.c)
                * (T_W + COEF_W + 1)'($signed({1'b0, lane_in.t}));
   assign l1_prod_in = prod1[PH_W-1:0];

   assign phase = l1_prod_ff + {c2.d[PH_W-D_SHIFT-1:0], {D_SHIFT{1'b0}}};
   assign k = phase[PH_W-1 -: PHASE_BITS];
   assign quad = k[PHASE_BITS-1 -: 2];
   assign j_ext = {1'b0, k[PHASE_BITS-3:0]};
   assign l2_addr_in = quad[0] ? (ADDR_W'(QUARTER) - j_ext) : j_ext;
   assign l2_neg_in = quad[0] ^ quad[1];

   assign rom_q = (l2_addr_ff == ADDR_W'(QUARTER)) ? COS_ROM_TOP
                                                    : COS_ROM[l2_addr_ff[PHASE_BITS-3:0]];
   assign cos_mag = $signed({1'b0, rom_q});
   assign l3_cos_in = l2_neg_ff ? -cos_mag : cos_mag;

   assign l4_sum_in = $signed({c4.a[COEF_W-1], c4.a, 14'b0})
                    + S_W'(c4.b) * S_W'(l3_cos_ff);

   // s * (2^CB - 1) + 2^27, then >> 28
   assign pos = l4_sum_ff[S_W-2:0];
   assign scaled = {pos, {COLOR_BITS{1'b0}}} - SC_W'(pos) + (SC_W'(1) << 27);
   assign v = scaled[SC_W-1:28];
   assign sat = (v > V_W'({COLOR_BITS{1'b1}})) ? {COLOR_BITS{1'b1}} : v[COLOR_BITS-1:0];
   assign fit = FIT_W'(sat);
   assign color_in = (l4_sum_ff <= 0) ? '0 : fit[OUT_W-1:0];

   always_ff @(posedge clock) begin
      l1_prod_ff <= l1_prod_in;
      l1_pal_ff  <= lane_in.pal;
      l2_addr_ff <= l2_addr_in;
      l2_neg_ff  <= l2_neg_in;
      l2_pal_ff  <= l1_pal_ff;
      l3_cos_ff  <= l3_cos_in;
      l3_pal_ff  <= l2_pal_ff;
      l4_sum_ff  <= l4_sum_in;
      color_ff   <= color_in;
   end

   assign color = color_ff;

endmodule

/* hdl/cosine_palette_color_map.sv */
// Top level of the cosine palette colour mapper.
//
//   channel  ports                                   transfer when
//   -------  --------------------------------------  -------------------------
//   input    start, busy, req_iteration_index        start && !busy
//   result   rsp_strobe, rsp_red/green/blue          rsp_strobe (no back-pressure)
//   config   csr_valid, csr_ready, csr_palette_select csr_valid && csr_ready
//
// One item per clock; each result passes through the eight register stages after
// its transfer: reciprocal multiply, remainder, phase fraction, then five stages
// in each colour lane (c*t, phase fold, ROM, a+b*cos, scale).
// Synchronous active-high reset clears the valid chain and palette_select;
// busy and csr_ready follow reset, so nothing transfers while it is held.
// The result side cannot stall, so the pipeline never holds.

`include "cosine_palette_color_map_macros.svh"

module cosine_palette_color_map import cpcm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              start,
   output logic              busy,
   input  logic [IDX_W-1:0]  req_iteration_index,
   // results
   output logic              rsp_strobe,
   output logic [OUT_W-1:0]  rsp_red,
   output logic [OUT_W-1:0]  rsp_green,
   output logic [OUT_W-1:0]  rsp_blue,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SEL_W-1:0]  csr_palette_select
);

   logic [SEL_W-1:0]   palette_ff;
   logic [SEL_W-1:0]   palette_in;
   logic [LATENCY-1:0] vld_ff;
   logic [LATENCY-1:0] vld_in;

   // stage 1: integer part times reciprocal of the period
   logic [PQ_W-1:0]    s1_prod_ff;
   logic [PQ_W-1:0]    s1_prod_in;
   logic [Q_W-1:0]     s1_q_ff;
   logic [FRAC_W-1:0]  s1_lo_ff;
   pal_type            s1_pal_ff;
   pal_type            s1_pal_in;
   // stage 2: remainder modulo the period
   logic [R_W-1:0]     s2_rm_ff;
   logic [R_W-1:0]     s2_rm_in;
   logic [FRAC_W-1:0]  s2_lo_ff;
   pal_type            s2_pal_ff;
   // stage 3: phase fraction t
   lane_in_type        s3_lane_ff;
   lane_in_type        s3_lane_in;

   logic               accept;
   logic               csr_write;
   logic [Q_W-1:0]     quot;
   logic [Q_W-1:0]     rem_full;
   logic [X_W-1:0]     x;
   logic [PT_W-1:0]    prod_t;

   assign busy = reset;
   assign csr_ready = !reset;
   assign accept = start && !busy;
   assign csr_write = csr_valid && csr_ready;

   assign palette_in = csr_write ? csr_palette_select : palette_ff;

   // unused codes fall back to the last palette
   assign s1_pal_in = (palette_ff > SEL_W'(PAL_4)) ? PAL_4 : pal_type'(palette_ff);
   assign s1_prod_in = PQ_W'(req_iteration_index[IDX_W-1:FRAC_W]) * PQ_W'(recip_q(s1_pal_in));

   // quotient is exact for every 16-bit integer part, so no correction step
   assign quot = Q_W'(s1_prod_ff[PQ_W-1:Q_SHIFT]);
   assign rem_full = s1_q_ff - Q_W'(quot * Q_W'(period_of(s1_pal_ff)));
   assign s2_rm_in = rem_full[R_W-1:0];

   // r = rm*256 + lo; t = floor(r*256 / P)
   assign x = {s2_rm_ff, s2_lo_ff, 8'b0};
   assign prod_t = PT_W'(x) * PT_W'(recip_t(s2_pal_ff));
   assign s3_lane_in.t = prod_t[T_SHIFT+T_W-1:T_SHIFT];
   assign s3_lane_in.pal = s2_pal_ff;

   assign vld_in = {vld_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= '0;
         vld_ff     <= '0;
      end else begin
         palette_ff <= palette_in;
         vld_ff     <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_prod_ff <= s1_prod_in;
      s1_q_ff    <= req_iteration_index[IDX_W-1:FRAC_W];
      s1_lo_ff   <= req_iteration_index[FRAC_W-1:0];
      s1_pal_ff  <= s1_pal_in;
      s2_rm_ff   <= s2_rm_in;
      s2_lo_ff   <= s1_lo_ff;
      s2_pal_ff  <= s1_pal_ff;
      s3_lane_ff <= s3_lane_in;
   end

   cpcm_lane u_lane_red (
      .clock   (clock),
      .chan    (CH_RED),
      .lane_in (s3_lane_ff),
      .color   (rsp_red)
   );

   cpcm_lane u_lane_green (
      .clock   (clock),
      .chan    (CH_GREEN),
      .lane_in (s3_lane_ff),
      .color   (rsp_green)
   );

   cpcm_lane u_lane_blue (
      .clock   (clock),
      .chan    (CH_BLUE),
      .lane_in (s3_lane_ff),
      .color   (rsp_blue)
   );

   assign rsp_strobe = vld_ff[LATENCY-1];

   // every result traces back to exactly one input transfer
   `CPCM_ASSERT_IMP(a_rsp_has_origin, clock, reset, rsp_strobe, $past(accept, LATENCY), "result strobe without matching input transfer")
   // reciprocal remainder must land inside the period
   `CPCM_ASSERT_IMP(a_rem_in_period, clock, reset, vld_ff[1], s2_rm_ff < period_of(s2_pal_ff), "remainder not below period")
   // palette codes are clamped on entry
   `CPCM_ASSERT_IMP(a_pal_clamped, clock, reset, vld_ff[0], s1_pal_ff <= PAL_4, "palette code out of range in pipeline")
   // a register write lands next cycle
   `CPCM_ASSERT_NXT(a_csr_written, clock, reset, csr_write, palette_ff == $past(csr_palette_select), "palette_select write lost")

endmodule
